// File: hdl/sli_pkg.sv
package sli_pkg;

  // list capacity
  localparam int unsigned DEPTH = 16;

  // count of entries needs to hold DEPTH itself
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // payload widths of the channels
  localparam int unsigned ValW = 32;
  localparam int unsigned StatW = 2;
  localparam int unsigned PosW = 4;
  localparam int unsigned OutCntW = 5;

  // request codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  localparam logic [StatW-1:0] ST_DONE = 2'd0;
  localparam logic [StatW-1:0] ST_FULL = 2'd1;
  localparam logic [StatW-1:0] ST_MISSING = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic act;
    logic signed [ValW-1:0] value;
    logic [CntW-1:0] count;
  } cell_ctrl_t;

endpackage

// File: hdl/sli_if.sv
interface sli_req_if;
  logic valid;
  logic ready;
  logic action;
  logic signed [sli_pkg::ValW-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface sli_rsp_if;
  logic valid;
  logic ready;
  logic [sli_pkg::StatW-1:0] status;
  logic [sli_pkg::PosW-1:0] position;
  logic [sli_pkg::OutCntW-1:0] count;

  modport source (output valid, output status, output position, output count, input ready);
  modport sink (input valid, input status, input position, input count, output ready);
endinterface

// File: hdl/sorted_list_insert_remove.sv
// a request's compare flags are registered when it is taken; the result is offered
//   from the result register, written in the update state once no earlier result is still held
// a new request is taken only in the idle state, after the compare step and the
//   shift step of the previous one, which all cells of the chain take together
// reset: rst_ni async active low empties the list (count zero); entry storage
//   is not cleared, slots at or above the count never affect a result
module sorted_list_insert_remove (
  input  logic       clk_i,
  input  logic       rst_ni,
  sli_req_if.sink    req_i,
  sli_rsp_if.source  rsp_o
);
  import sli_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD = 1'b1;

  logic state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic act_q;
  logic signed [ValW-1:0] value_q;

  logic rsp_valid_q;
  logic [StatW-1:0] status_q, status_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [OutCntW-1:0] rcnt_q;

  cell_ctrl_t ctrl;
  logic req_xfer;
  logic rsp_free;
  logic commit;

  logic signed [ValW-1:0] entry [DEPTH];
  logic [DEPTH-1:0] lt_vec;
  logic [DEPTH-1:0] le_vec;

  logic [CntW-1:0] pos_ins;
  logic [CntW-1:0] pos_rm;
  logic full;
  logic found;
  logic success;

  // handshakes
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_xfer = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  // broadcast to the cells: compare uses the incoming payload
  assign ctrl.cmp_en = req_xfer;
  assign ctrl.upd_en = commit;
  assign ctrl.act = req_xfer ? req_i.action : act_q;
  assign ctrl.value = req_xfer ? req_i.value : value_q;
  assign ctrl.count = cnt_q;

  // chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ValW-1:0] left_entry;
    logic left_le;
    logic signed [ValW-1:0] right_entry;

    if (g == 0) begin : g_first
      assign left_entry = entry[g];
      assign left_le = 1'b1;
    end else begin : g_mid
      assign left_entry = entry[g-1];
      assign left_le = le_vec[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_entry = entry[g];
    end else begin : g_inner
      assign right_entry = entry[g+1];
    end

    sli_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .idx_i        (CntW'(g)),
      .ctrl_i       (ctrl),
      .left_entry_i (left_entry),
      .left_le_i    (left_le),
      .right_entry_i(right_entry),
      .entry_o      (entry[g]),
      .lt_o         (lt_vec[g]),
      .le_o         (le_vec[g])
    );
  end

  // positions: flags form a prefix of ones, so take the first zero
  always_comb begin
    pos_ins = CntW'(DEPTH);
    pos_rm = CntW'(DEPTH);
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!le_vec[i]) pos_ins = CntW'(i);
      if (!lt_vec[i]) pos_rm = CntW'(i);
    end
  end

  assign full = (cnt_q == CntW'(DEPTH));
  assign found = |(le_vec & ~lt_vec);
  assign success = (act_q == ACT_INSERT) ? !full : found;
  assign commit = (state_q == ST_UPD) && rsp_free && success;

  // result and new count
  always_comb begin
    cnt_d = cnt_q;
    status_d = ST_DONE;
    pos_d = '0;
    if (act_q == ACT_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        cnt_d = cnt_q + 1'b1;
        pos_d = PosW'(pos_ins);
      end
    end else begin
      if (!found) begin
        status_d = ST_MISSING;
      end else begin
        cnt_d = cnt_q - 1'b1;
        pos_d = PosW'(pos_rm);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_xfer) state_d = ST_UPD;
      ST_UPD: if (rsp_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_UPD && rsp_free) begin
        cnt_q <= cnt_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      act_q <= req_i.action;
      value_q <= req_i.value;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD && rsp_free) begin
      status_q <= status_d;
      pos_q <= pos_d;
      rcnt_q <= OutCntW'(cnt_d);
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.status = status_q;
  assign rsp_o.position = pos_q;
  assign rsp_o.count = rcnt_q;

  // count stays within capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above capacity");

  // strict-less flags are a subset of less-or-equal flags
  a_flag_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> ((lt_vec & ~le_vec) == '0))
    else $error("compare flags inconsistent");

  // a successful insert grows the list by one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && act_q == ACT_INSERT) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("insert did not grow count");

  // a successful remove shrinks the list by one
  a_rm_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && act_q == ACT_REMOVE) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("remove did not shrink count");

  // no request transfer while a shift step is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> !req_i.ready)
    else $error("request taken during update");

endmodule

// File: hdl/sli_cell.sv
module sli_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [sli_pkg::CntW-1:0]           idx_i,
  input  sli_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [sli_pkg::ValW-1:0]    left_entry_i,
  input  logic                               left_le_i,
  input  logic signed [sli_pkg::ValW-1:0]    right_entry_i,
  output logic signed [sli_pkg::ValW-1:0]    entry_o,
  output logic                               lt_o,
  output logic                               le_o
);
  import sli_pkg::*;

  logic signed [ValW-1:0] entry_q;
  logic lt_q;
  logic le_q;
  logic occ;

  // cell holds a live entry when its index is below the count
  assign occ = idx_i < ctrl_i.count;

  // compare flags, taken when a request transfer happens
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      le_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      lt_q <= occ && (entry_q < ctrl_i.value);
      le_q <= occ && (entry_q <= ctrl_i.value);
    end
  end

  // shift step: insert moves entries up, remove moves them down
  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd_en) begin
      if (ctrl_i.act == ACT_INSERT) begin
        if (!le_q) begin
          entry_q <= left_le_i ? ctrl_i.value : left_entry_i;
        end
      end else begin
        if (!lt_q) begin
          entry_q <= right_entry_i;
        end
      end
    end
  end

  assign entry_o = entry_q;
  assign lt_o = lt_q;
  assign le_o = le_q;

endmodule
